// File: rtl/message_codec_byte_serializer_macros.svh
// Assertion macros shared by the serializer RTL.
// Defining NO_ASSERTIONS compiles every use down to nothing.
`ifndef MESSAGE_CODEC_BYTE_SERIALIZER_MACROS_SVH
`define MESSAGE_CODEC_BYTE_SERIALIZER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MCBS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("serializer: invariant violated");
`define MCBS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("serializer: same-cycle implication violated");
`define MCBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("serializer: next-cycle implication violated");
`else
`define MCBS_ASSERT_ALWAYS(label, clk, rst, cond)
`define MCBS_ASSERT_SAME(label, clk, rst, ante, cons)
`define MCBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/mcbs_pkg.sv
// Types, codes and header builder for the message codec byte serializer.
// No dependencies; used by mcbs_shifter and the top level of the block.
package mcbs_pkg;

   localparam int unsigned CountW = 4;

   localparam logic [2:0] OP_STR_HDR   = 3'd0;
   localparam logic [2:0] OP_STR_BYTE  = 3'd1;
   localparam logic [2:0] OP_LIST_HDR  = 3'd2;
   localparam logic [2:0] OP_FLOAT_ELT = 3'd3;
   localparam logic [2:0] OP_MAP_HDR   = 3'd4;
   localparam logic [2:0] OP_INT32     = 3'd5;

   localparam logic [7:0] TAG_INT32    = 8'd3;
   localparam logic [7:0] TAG_STRING   = 8'd7;
   localparam logic [7:0] TAG_F64_LIST = 8'd11;
   localparam logic [7:0] TAG_MAP      = 8'd13;

   localparam logic [7:0]  SIZE16_MARK  = 8'd254;
   localparam logic [7:0]  SIZE32_MARK  = 8'd255;
   localparam logic [31:0] SIZE16_LIMIT = 32'h0000_ffff;

   localparam logic [CountW-1:0] CNT_BYTE  = CountW'(1);
   localparam logic [CountW-1:0] CNT_INT32 = CountW'(5);
   localparam logic [CountW-1:0] CNT_FLOAT = CountW'(8);

   typedef struct packed {
      logic [63:0]       word;
      logic [CountW-1:0] count;
   } load_type;

   typedef struct packed {
      logic [7:0]        out_byte;
      logic              busy;
      logic              final_byte;
      logic [CountW-1:0] count;
   } shift_status_type;

   function automatic load_type build_header(input logic [7:0] tag, input logic [31:0] len);
      load_type r;
      r.word  = '0;
      r.count = '0;
      if (len < {24'b0, SIZE16_MARK}) begin
         r.word  = {48'b0, len[7:0], tag};
         r.count = CountW'(2);
      end else if (len <= SIZE16_LIMIT) begin
         r.word  = {32'b0, len[15:0], SIZE16_MARK, tag};
         r.count = CountW'(4);
      end else begin
         r.word  = {16'b0, len, SIZE32_MARK, tag};
         r.count = CountW'(6);
      end
      return r;
   endfunction

endpackage

// File: rtl/mcbs_shifter.sv
// Byte-wide shift register that releases one byte of an item per cycle while shift is high.
// Depends on mcbs_pkg for the load and status types.
module mcbs_shifter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  mcbs_pkg::load_type         load_item,
   input  logic                       shift,
   output mcbs_pkg::shift_status_type status
);

   logic [63:0]                   data_ff, data_in;
   logic [mcbs_pkg::CountW-1:0]   count_ff, count_in;

   always_comb begin
      data_in  = data_ff;
      count_in = count_ff;
      if (load) begin
         data_in  = load_item.word;
         count_in = load_item.count;
      end else if (shift && count_ff != '0) begin
         data_in  = {8'b0, data_ff[63:8]};
         count_in = count_ff - mcbs_pkg::CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.out_byte   = data_ff[7:0];
   assign status.busy       = (count_ff != '0);
   assign status.final_byte = (count_ff == mcbs_pkg::CNT_BYTE);
   assign status.count      = count_ff;

endmodule

// File: rtl/mcbs_align.sv
// Byte offset from the start of the message, kept modulo the list alignment.
// No package dependencies.
module mcbs_align #(
   parameter int unsigned LIST_ALIGNMENT = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic clear,
   input  logic step,
   output logic wrap_next
);

   localparam int unsigned OffW = (LIST_ALIGNMENT > 2) ? $clog2(LIST_ALIGNMENT) : 1;
   localparam logic [OffW-1:0] LastOff = OffW'(LIST_ALIGNMENT - 1);

   logic [OffW-1:0] offset_ff, offset_in;

   assign wrap_next = (offset_ff == LastOff);

   always_comb begin
      offset_in = offset_ff;
      if (clear) begin
         offset_in = '0;
      end else if (step) begin
         offset_in = wrap_next ? '0 : offset_ff + OffW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

// File: rtl/message_codec_byte_serializer.sv
// Top level of the message codec byte serializer: item decode and byte sequencer.
// Depends on mcbs_pkg, mcbs_shifter, mcbs_align and the assertion macro header.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_operation, req_start_of_message,
//           |           | req_length, req_payload
//   rsp     | out       | rsp_valid, rsp_ready, rsp_out_byte, rsp_last
//
// One item at a time: after accept, one byte leaves per cycle while rsp_ready is high.
// An item gives N bytes (1 to 8, list header up to 6 + alignment - 1).
// The byte shift register releases the bytes; the pad phase emits zeros.
// Unknown operations produce no bytes and the block is ready again next cycle.
// A stall on rsp_ready holds the current byte; reset returns to idle, offset zero.
`include "message_codec_byte_serializer_macros.svh"

module message_codec_byte_serializer #(
   parameter int unsigned LIST_ALIGNMENT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic        req_start_of_message,
   input  logic [31:0] req_length,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PAD
   } state_type;

   state_type                  state_ff, state_in;
   logic                       pad_ff, pad_in;
   logic                       req_fire, rsp_fire;
   logic                       wrap_next;
   logic                       pad_more;
   mcbs_pkg::load_type         load_item;
   mcbs_pkg::shift_status_type status;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign pad_more  = pad_ff && !wrap_next;

   always_comb begin
      load_item = '0;
      unique case (req_operation)
         mcbs_pkg::OP_STR_HDR: begin
            load_item = mcbs_pkg::build_header(mcbs_pkg::TAG_STRING, req_length);
         end
         mcbs_pkg::OP_STR_BYTE: begin
            load_item.word  = {56'b0, req_payload[7:0]};
            load_item.count = mcbs_pkg::CNT_BYTE;
         end
         mcbs_pkg::OP_LIST_HDR: begin
            load_item = mcbs_pkg::build_header(mcbs_pkg::TAG_F64_LIST, req_length);
         end
         mcbs_pkg::OP_FLOAT_ELT: begin
            load_item.word  = req_payload;
            load_item.count = mcbs_pkg::CNT_FLOAT;
         end
         mcbs_pkg::OP_MAP_HDR: begin
            load_item = mcbs_pkg::build_header(mcbs_pkg::TAG_MAP, req_length);
         end
         mcbs_pkg::OP_INT32: begin
            load_item.word  = {24'b0, req_payload[31:0], mcbs_pkg::TAG_INT32};
            load_item.count = mcbs_pkg::CNT_INT32;
         end
         default: begin
            load_item = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid    = 1'b0;
      rsp_out_byte = 8'd0;
      rsp_last     = 1'b0;
      unique case (state_ff)
         ST_SHIFT: begin
            rsp_valid    = 1'b1;
            rsp_out_byte = status.out_byte;
            rsp_last     = status.final_byte && !pad_more;
         end
         ST_PAD: begin
            rsp_valid    = 1'b1;
            rsp_out_byte = 8'd0;
            rsp_last     = wrap_next;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pad_in   = pad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pad_in = (req_operation == mcbs_pkg::OP_LIST_HDR) && (req_length != 32'd0);
               if (load_item.count != '0) begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (rsp_fire && status.final_byte) begin
               state_in = pad_more ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            if (rsp_fire && wrap_next) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pad_ff   <= pad_in;
      end
   end

   mcbs_shifter u_shifter (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .load_item (load_item),
      .shift     (rsp_fire && state_ff == ST_SHIFT),
      .status    (status)
   );

   mcbs_align #(
      .LIST_ALIGNMENT (LIST_ALIGNMENT)
   ) u_align (
      .clock     (clock),
      .reset     (reset),
      .clear     (req_fire && req_start_of_message),
      .step      (rsp_fire),
      .wrap_next (wrap_next)
   );

   `MCBS_ASSERT_ALWAYS(a_no_overlap, clock, reset, !(req_ready && rsp_valid))
   `MCBS_ASSERT_SAME(a_pad_after_shift, clock, reset, state_ff == ST_PAD, !status.busy)
   `MCBS_ASSERT_SAME(a_shift_has_bytes, clock, reset, state_ff == ST_SHIFT, status.busy)
   `MCBS_ASSERT_NEXT(a_ready_after_last, clock, reset, rsp_fire && rsp_last, req_ready)
   `MCBS_ASSERT_NEXT(a_float_loads_eight, clock, reset,
      req_fire && req_operation == mcbs_pkg::OP_FLOAT_ELT,
      status.count == mcbs_pkg::CNT_FLOAT)

endmodule
